// ----- design/fsc_pkg.sv -----
// Shared types, signature tables and brand decoding for the file signature classifier.
// No dependencies; used by fsc_scan and file_signature_classifier.
`default_nettype none

package fsc_pkg;

	localparam int HEADER_BYTES = 32;
	localparam int POS_W        = $clog2(HEADER_BYTES + 1);
	localparam int NUM_SIGS     = 17;
	localparam int ISO_SIG      = 9;
	localparam int PAT_DEPTH    = 16;

	// ISO base media brand offsets, as byte counts after the brand's last byte
	localparam int MAJOR_END        = 12;
	localparam int COMPAT_FIRST_END = 20;

	typedef logic [3:0] fmt_t;

	localparam fmt_t FMT_UNKNOWN = 4'd0;
	localparam fmt_t FMT_JPEG    = 4'd1;
	localparam fmt_t FMT_PNG     = 4'd2;
	localparam fmt_t FMT_BMP     = 4'd3;
	localparam fmt_t FMT_GIF     = 4'd4;
	localparam fmt_t FMT_TIFF    = 4'd5;
	localparam fmt_t FMT_ICO     = 4'd6;
	localparam fmt_t FMT_WEBP    = 4'd7;
	localparam fmt_t FMT_HEIF    = 4'd8;
	localparam fmt_t FMT_AVIF    = 4'd9;
	localparam fmt_t FMT_JPEG_XL = 4'd10;
	localparam fmt_t FMT_ZIP     = 4'd11;
	localparam fmt_t FMT_7Z      = 4'd12;
	localparam fmt_t FMT_RAR     = 4'd13;

	typedef logic [1:0] brand_t;

	localparam brand_t BRAND_NONE = 2'd0;
	localparam brand_t BRAND_AVIF = 2'd1;
	localparam brand_t BRAND_HEIF = 2'd2;

	typedef struct packed {
		fmt_t code;
		logic is_image;
		logic is_archive;
	} fsc_result_t;

	localparam logic [3:0] SIG_LEN [NUM_SIGS] = '{
		4'd3, 4'd8, 4'd2, 4'd6, 4'd6, 4'd4, 4'd4, 4'd4, 4'd12,
		4'd12, 4'd2, 4'd4, 4'd4, 4'd4, 4'd6, 4'd7, 4'd8
	};

	localparam logic [PAT_DEPTH-1:0] SIG_CARE [NUM_SIGS] = '{
		16'h0007, 16'h00FF, 16'h0003, 16'h003F, 16'h003F, 16'h000F, 16'h000F,
		16'h000F, 16'h0F0F, 16'h00F0, 16'h0003, 16'h000F, 16'h000F, 16'h000F,
		16'h003F, 16'h007F, 16'h00FF
	};

	localparam logic [7:0] SIG_PAT [NUM_SIGS][PAT_DEPTH] = '{
		'{0: 8'hFF, 1: 8'hD8, 2: 8'hFF, default: 8'h00},
		'{0: 8'h89, 1: 8'h50, 2: 8'h4E, 3: 8'h47, 4: 8'h0D, 5: 8'h0A, 6: 8'h1A,
			7: 8'h0A, default: 8'h00},
		'{0: 8'h42, 1: 8'h4D, default: 8'h00},
		'{0: 8'h47, 1: 8'h49, 2: 8'h46, 3: 8'h38, 4: 8'h37, 5: 8'h61, default: 8'h00},
		'{0: 8'h47, 1: 8'h49, 2: 8'h46, 3: 8'h38, 4: 8'h39, 5: 8'h61, default: 8'h00},
		'{0: 8'h49, 1: 8'h49, 2: 8'h2A, 3: 8'h00, default: 8'h00},
		'{0: 8'h4D, 1: 8'h4D, 2: 8'h00, 3: 8'h2A, default: 8'h00},
		'{0: 8'h00, 1: 8'h00, 2: 8'h01, 3: 8'h00, default: 8'h00},
		'{0: 8'h52, 1: 8'h49, 2: 8'h46, 3: 8'h46, 8: 8'h57, 9: 8'h45, 10: 8'h42,
			11: 8'h50, default: 8'h00},
		'{4: 8'h66, 5: 8'h74, 6: 8'h79, 7: 8'h70, default: 8'h00},
		'{0: 8'hFF, 1: 8'h0A, default: 8'h00},
		'{0: 8'h50, 1: 8'h4B, 2: 8'h03, 3: 8'h04, default: 8'h00},
		'{0: 8'h50, 1: 8'h4B, 2: 8'h05, 3: 8'h06, default: 8'h00},
		'{0: 8'h50, 1: 8'h4B, 2: 8'h07, 3: 8'h08, default: 8'h00},
		'{0: 8'h37, 1: 8'h7A, 2: 8'hBC, 3: 8'hAF, 4: 8'h27, 5: 8'h1C, default: 8'h00},
		'{0: 8'h52, 1: 8'h61, 2: 8'h72, 3: 8'h21, 4: 8'h1A, 5: 8'h07, 6: 8'h00,
			default: 8'h00},
		'{0: 8'h52, 1: 8'h61, 2: 8'h72, 3: 8'h21, 4: 8'h1A, 5: 8'h07, 6: 8'h01,
			7: 8'h00, default: 8'h00}
	};

	// ISO entry has no code of its own; the brands decide it
	localparam fmt_t SIG_CODE [NUM_SIGS] = '{
		FMT_JPEG, FMT_PNG, FMT_BMP, FMT_GIF, FMT_GIF, FMT_TIFF, FMT_TIFF, FMT_ICO,
		FMT_WEBP, FMT_UNKNOWN, FMT_JPEG_XL, FMT_ZIP, FMT_ZIP, FMT_ZIP, FMT_7Z,
		FMT_RAR, FMT_RAR
	};

	function automatic brand_t brand_kind(input logic [31:0] w);
		brand_t k;
		k = BRAND_NONE;
		if (w == 32'h61766966 || w == 32'h61766973) begin
			k = BRAND_AVIF;
		end else if (w == 32'h68656963 || w == 32'h68656978 ||
			w == 32'h68657663 || w == 32'h68657678 ||
			w == 32'h6D696631 || w == 32'h6D736631) begin
			k = BRAND_HEIF;
		end
		return k;
	endfunction

	function automatic fmt_t kind_code(input brand_t k);
		fmt_t c;
		case (k)
			BRAND_AVIF: c = FMT_AVIF;
			BRAND_HEIF: c = FMT_HEIF;
			default:    c = FMT_UNKNOWN;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- design/file_signature_classifier.sv -----
// Result path: a last beat's result goes through the input register, then scan logic into the
// result register, which it enters only when that register is free.
// Throughput: one beat per cycle; the input stalls only when a last beat waits
// on a result register that is still held by result_stall.
// Reset (arst_n low): both registers empty, scan state back to the start of a file.
// Top level; instantiates fsc_scan, uses fsc_pkg.
`default_nettype none

module file_signature_classifier (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       byte_present,
	input  wire logic       last,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [3:0]      format_code,
	output logic            is_image,
	output logic            is_archive
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 present_s1;
	logic                 last_s1;
	logic                 out_free;
	logic                 advance;
	logic                 in_accept;
	fsc_pkg::fsc_result_t res;
	fsc_pkg::fsc_result_t res_q;

	assign out_free   = !result_valid || !result_stall;
	assign advance    = valid_s1 && (!last_s1 || out_free);
	assign byte_stall = valid_s1 && !advance;
	assign in_accept  = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1    <= data_byte;
			present_s1 <= byte_present;
			last_s1    <= last;
		end
	end

	fsc_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.data_byte    (byte_s1),
		.byte_present (present_s1),
		.last         (last_s1),
		.result       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && last_s1) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= res;
		end
	end

	assign format_code = res_q.code;
	assign is_image    = res_q.is_image;
	assign is_archive  = res_q.is_archive;

endmodule

`default_nettype wire

// ----- design/fsc_scan.sv -----
// Header scan state: position, per-signature match flags, byte window, brands.
// Updates on each advanced beat and classifies on the last one. Uses fsc_pkg.
`default_nettype none

module fsc_scan (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  advance,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  byte_present,
	input  wire logic                  last,
	output fsc_pkg::fsc_result_t       result
);

	logic [fsc_pkg::POS_W-1:0]    pos_q, pos_nx;
	logic [fsc_pkg::NUM_SIGS-1:0] alive_q, alive_nx;
	logic [31:0]                  win_q, win_nx;
	fsc_pkg::brand_t              major_q, major_nx;
	fsc_pkg::brand_t              compat_q, compat_nx;
	logic                         take;
	logic                         done;
	fsc_pkg::fmt_t                code;

	always_comb begin
		take      = byte_present && (pos_q < fsc_pkg::POS_W'(fsc_pkg::HEADER_BYTES));
		pos_nx    = pos_q;
		alive_nx  = alive_q;
		win_nx    = win_q;
		major_nx  = major_q;
		compat_nx = compat_q;
		if (take) begin
			for (int s = 0; s < fsc_pkg::NUM_SIGS; s++) begin
				if (pos_q < fsc_pkg::POS_W'(fsc_pkg::SIG_LEN[s]) &&
					fsc_pkg::SIG_CARE[s][pos_q[3:0]] &&
					data_byte != fsc_pkg::SIG_PAT[s][pos_q[3:0]]) begin
					alive_nx[s] = 1'b0;
				end
			end
			win_nx = {win_q[23:0], data_byte};
			pos_nx = pos_q + 1'b1;
			if (pos_nx == fsc_pkg::POS_W'(fsc_pkg::MAJOR_END)) begin
				major_nx = fsc_pkg::brand_kind(win_nx);
			end
			// compatible brands end on every fourth byte from offset 20
			if (pos_nx >= fsc_pkg::POS_W'(fsc_pkg::COMPAT_FIRST_END) &&
				pos_nx[1:0] == 2'b00 && compat_q == fsc_pkg::BRAND_NONE) begin
				compat_nx = fsc_pkg::brand_kind(win_nx);
			end
		end
	end

	// first live signature in priority order whose length the header covers; ISO needs a brand
	always_comb begin
		code = fsc_pkg::FMT_UNKNOWN;
		done = 1'b0;
		for (int s = 0; s < fsc_pkg::NUM_SIGS; s++) begin
			if (!done && alive_nx[s] &&
				pos_nx >= fsc_pkg::POS_W'(fsc_pkg::SIG_LEN[s])) begin
				if (s == fsc_pkg::ISO_SIG) begin
					if (major_nx != fsc_pkg::BRAND_NONE) begin
						code = fsc_pkg::kind_code(major_nx);
						done = 1'b1;
					end else if (compat_nx != fsc_pkg::BRAND_NONE) begin
						code = fsc_pkg::kind_code(compat_nx);
						done = 1'b1;
					end
				end else begin
					code = fsc_pkg::SIG_CODE[s];
					done = 1'b1;
				end
			end
		end
	end

	assign result.code       = code;
	assign result.is_image   = (code != fsc_pkg::FMT_UNKNOWN) && (code <= fsc_pkg::FMT_JPEG_XL);
	assign result.is_archive = (code >= fsc_pkg::FMT_ZIP) && (code <= fsc_pkg::FMT_RAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			alive_q  <= '1;
			win_q    <= '0;
			major_q  <= fsc_pkg::BRAND_NONE;
			compat_q <= fsc_pkg::BRAND_NONE;
		end else if (advance) begin
			if (last) begin
				pos_q    <= '0;
				alive_q  <= '1;
				win_q    <= '0;
				major_q  <= fsc_pkg::BRAND_NONE;
				compat_q <= fsc_pkg::BRAND_NONE;
			end else begin
				pos_q    <= pos_nx;
				alive_q  <= alive_nx;
				win_q    <= win_nx;
				major_q  <= major_nx;
				compat_q <= compat_nx;
			end
		end
	end

endmodule

`default_nettype wire
